>>> rtl/rgb_to_hsl_pixel_assert.svh
// Assertion macros for the RGB to HSL pixel converter RTL, used by the division cell.
`ifndef RGB_TO_HSL_PIXEL_ASSERT_SVH
`define RGB_TO_HSL_PIXEL_ASSERT_SVH

// Same-cycle implication, clocked on clk, off while arst_n is low.
`define RTHP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rthp assertion failed");

// Next-cycle implication, clocked on clk, off while arst_n is low.
`define RTHP_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rthp assertion failed");

`endif

>>> rtl/rthp_pkg.sv
// Types and constants shared by the RGB to HSL pixel converter.
package rthp_pkg;

	localparam int CH_W   = 8;            // channel and result width
	localparam int QUO_W  = 8;            // quotient bits, one division cell each
	localparam int SUM_W  = CH_W + 1;     // max + min
	localparam int NUM_W  = CH_W + 3;     // hue numerator and 6*d
	localparam int REM_W  = NUM_W + CH_W; // 255 * hue numerator
	localparam int DSH_W  = NUM_W + QUO_W - 1; // divisor aligned to top quotient bit

	localparam logic [SUM_W-1:0] FULL_SCALE  = SUM_W'(255);
	localparam logic [SUM_W-1:0] TWICE_SCALE = SUM_W'(510);

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} rthp_pixel_t;

	typedef struct packed {
		logic [CH_W-1:0] hue;
		logic [CH_W-1:0] saturation;
		logic [CH_W-1:0] lightness;
	} rthp_hsl_t;

	// One restoring-division lane: partial remainder, shifted divisor, quotient so far.
	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [DSH_W-1:0] dsh;
		logic [QUO_W-1:0] quo;
	} rthp_lane_t;

	typedef struct packed {
		rthp_lane_t      hue;
		rthp_lane_t      sat;
		logic [CH_W-1:0] lightness;
	} rthp_stage_t;

endpackage

>>> rtl/rgb_to_hsl_pixel.sv
// RGB to HSL pixel converter: top level, front stage plus a chain of division cells.
// One pixel in, one HSL result out, with a throughput of one pixel per clock while
// hsl_ready does not stall the output. The first register stage finds the channel
// maximum and minimum, lightness, and the dividends and divisors for hue and
// saturation; eight identical division cells follow, each resolving one quotient
// bit of both divisions (restoring, most significant bit first), and the last cell's
// register drives the output. Every stage has its own valid bit and takes a new
// pixel whenever it is empty or its successor is taking its contents, so bubbles
// close up and a stalled output holds only as many pixels as there are stages. A
// grey pixel yields zero hue and saturation; on a tied maximum red wins, then green.
// No state survives between pixels and no configuration exists.
module rgb_to_hsl_pixel import rthp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pixel_valid,
	output logic        pixel_ready,
	input  rthp_pixel_t pixel,
	output logic        hsl_valid,
	input  logic        hsl_ready,
	output rthp_hsl_t   hsl
);

	// Stage k feeds cell k; stage 0 comes from the front stage.
	logic        stg_valid [QUO_W+1];
	logic        stg_ready [QUO_W+1];
	rthp_stage_t stg_data  [QUO_W+1];

	rthp_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pixel_valid),
		.in_ready  (pixel_ready),
		.in_data   (pixel),
		.out_valid (stg_valid[0]),
		.out_ready (stg_ready[0]),
		.out_data  (stg_data[0])
	);

	// Advance one quotient bit per cell, most significant first.
	for (genvar k = 0; k < QUO_W; k++) begin : g_cell
		rthp_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (stg_valid[k]),
			.in_ready  (stg_ready[k]),
			.in_data   (stg_data[k]),
			.out_valid (stg_valid[k+1]),
			.out_ready (stg_ready[k+1]),
			.out_data  (stg_data[k+1])
		);
	end

	// The last cell's register is the output register.
	assign hsl_valid          = stg_valid[QUO_W];
	assign stg_ready[QUO_W]   = hsl_ready;
	assign hsl.hue            = stg_data[QUO_W].hue.quo;
	assign hsl.saturation     = stg_data[QUO_W].sat.quo;
	assign hsl.lightness      = stg_data[QUO_W].lightness;

endmodule

>>> rtl/rthp_prep.sv
// Front stage: channel max/min, lightness, and dividend/divisor setup for both lanes.
module rthp_prep import rthp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  rthp_pixel_t in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output rthp_stage_t out_data
);

	logic              red_max, grn_max, grey;
	logic [CH_W-1:0]   mx, mn, d;
	logic [SUM_W-1:0]  sum, den;
	logic [NUM_W-1:0]  r_x, g_x, b_x, d_x, d2, d4, d6, num, hue_div;
	logic [CH_W-1:0]   sat_div;
	rthp_stage_t       nxt;
	logic              valid_q;
	rthp_stage_t       data_q;

	always_comb begin
		red_max = (in_data.red >= in_data.green) && (in_data.red >= in_data.blue);
		grn_max = !red_max && (in_data.green >= in_data.blue);
		mx = red_max ? in_data.red : (grn_max ? in_data.green : in_data.blue);
		if ((in_data.red <= in_data.green) && (in_data.red <= in_data.blue)) begin
			mn = in_data.red;
		end else if (in_data.green <= in_data.blue) begin
			mn = in_data.green;
		end else begin
			mn = in_data.blue;
		end
		d    = mx - mn;
		grey = (d == '0);
		sum  = {1'b0, mx} + {1'b0, mn};
		den  = (sum <= FULL_SCALE) ? sum : (TWICE_SCALE - sum);

		r_x = NUM_W'(in_data.red);
		g_x = NUM_W'(in_data.green);
		b_x = NUM_W'(in_data.blue);
		d_x = NUM_W'(d);
		d2  = d_x << 1;
		d4  = d_x << 2;
		d6  = d4 + d2;

		// Offset the sector so the hue numerator never goes negative.
		if (red_max) begin
			num = (in_data.green < in_data.blue) ? (g_x + d6 - b_x) : (g_x - b_x);
		end else if (grn_max) begin
			num = b_x + d2 - r_x;
		end else begin
			num = r_x + d4 - g_x;
		end

		// A grey pixel has a zero numerator; a divisor of one keeps the quotient zero.
		hue_div = grey ? NUM_W'(1) : d6;
		sat_div = grey ? CH_W'(1) : den[CH_W-1:0];

		nxt.hue.rem   = {num, {CH_W{1'b0}}} - REM_W'(num);
		nxt.hue.dsh   = {hue_div, {(QUO_W-1){1'b0}}};
		nxt.hue.quo   = '0;
		nxt.sat.rem   = REM_W'({d, {CH_W{1'b0}}} - {{CH_W{1'b0}}, d});
		nxt.sat.dsh   = DSH_W'({sat_div, {(QUO_W-1){1'b0}}});
		nxt.sat.quo   = '0;
		nxt.lightness = sum[SUM_W-1:1];
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

>>> rtl/rthp_div_cell.sv
// Division cell: resolves one quotient bit for the hue and saturation lanes.
module rthp_div_cell import rthp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  rthp_stage_t in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output rthp_stage_t out_data
);

	`include "rgb_to_hsl_pixel_assert.svh"

	logic        hue_ge, sat_ge;
	rthp_stage_t nxt;
	logic        valid_q;
	rthp_stage_t data_q;

	always_comb begin
		hue_ge = in_data.hue.rem >= REM_W'(in_data.hue.dsh);
		sat_ge = in_data.sat.rem >= REM_W'(in_data.sat.dsh);

		nxt.hue.rem   = hue_ge ? (in_data.hue.rem - REM_W'(in_data.hue.dsh)) : in_data.hue.rem;
		nxt.hue.dsh   = in_data.hue.dsh >> 1;
		nxt.hue.quo   = {in_data.hue.quo[QUO_W-2:0], hue_ge};
		nxt.sat.rem   = sat_ge ? (in_data.sat.rem - REM_W'(in_data.sat.dsh)) : in_data.sat.rem;
		nxt.sat.dsh   = in_data.sat.dsh >> 1;
		nxt.sat.quo   = {in_data.sat.quo[QUO_W-2:0], sat_ge};
		nxt.lightness = in_data.lightness;
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

	// Restoring division needs the remainder below twice the current divisor.
	`RTHP_ASSERT_NOW(a_hue_rem_bound, in_valid, in_data.hue.rem < {in_data.hue.dsh, 1'b0})
	`RTHP_ASSERT_NOW(a_sat_rem_bound, in_valid, in_data.sat.rem < {in_data.sat.dsh, 1'b0})
	`RTHP_ASSERT_NXT(a_take_fills, in_valid && in_ready, out_valid)
	`RTHP_ASSERT_NXT(a_stall_keeps, out_valid && !out_ready, out_valid && $stable(out_data))

endmodule
